// ===== rtl/core/sfdh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame deframer package
// Shared constants and types for the deframer front, command queue and
// health back end.
// ----------------------------------------------------------------------------
package sfdh_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 30;
  localparam int unsigned WORD_COUNT      = 6;
  localparam int unsigned WORD_W          = 32;
  localparam int unsigned WORD_BASE       = 4;

  localparam logic [7:0] SYNC_FIRST        = 8'hFA;
  localparam logic [7:0] SYNC_SECOND       = 8'hFF;
  localparam logic [7:0] STALE_LIMIT_RESET = 8'd20;
  localparam logic [7:0] RATE_PERIOD_RESET = 8'd10;
  localparam logic [7:0] STALE_MAX         = 8'hFF;

  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_TICK    = 1'b1;
  localparam logic KIND_FRAME  = 1'b0;
  localparam logic KIND_HEALTH = 1'b1;

  localparam logic CFG_STALE_LIMIT = 1'b0;
  localparam logic CFG_RATE_PERIOD = 1'b1;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned CMD_PTR_W = 1;
  localparam int unsigned CMD_CNT_W = 2;

  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 216;

  typedef struct packed {
    logic                                is_tick;
    logic [WORD_COUNT-1:0][WORD_W-1:0]   words;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/sensor_frame_deframer_health_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sensor frame deframer with link health monitor
// Input stream: tuser selects a received byte (0) or a monitor tick (1),
// tdata carries the byte. Each tick beat yields one health result; a byte
// beat yields a frame result only when it completes a window that starts
// with the sync pair and sums to zero over bytes one and up.
// Output stream: tuser gives the result kind, tdata the six raw 32-bit
// frame words, the fail flag and the latched frame rate.
// One input beat is taken per cycle while the command queue has room. A
// result is registered first in the command queue and then in the output
// register of the health stage.
// The two-entry command queue and the output register let the input keep
// flowing while a result waits; when the receiver stalls, the queue fills
// and input tready falls. Bytes that make no result still need queue room.
// Reset clears the window, the counters and the queue, and loads the
// default stale limit of 20 and rate period of 10. Configuration beats are
// always taken at once; index 0 is the stale limit, index 1 the period.
// ----------------------------------------------------------------------------
module sensor_frame_deframer_health_top import sfdh_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // rx_byte
  input  wire logic                  s_axis_tuser,  // req_type
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // rate_x_word, rate_z_word, rate_y_word, roll_word, pitch_word, yaw_word,
  // link_failed, frame_rate, zero fill
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tuser,  // result_kind
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic                  cfg_index_i,
  input  wire logic [7:0]            cfg_data_i
);

  localparam int unsigned PAY_W = WORD_COUNT * WORD_W + 17;

  logic                               accept;
  logic                               push;
  logic                               full;
  logic                               pop;
  logic                               cmd_valid;
  cmd_t                               front_cmd;
  cmd_t                               queue_cmd;
  logic [WORD_COUNT-1:0][WORD_W-1:0]  out_words;
  logic                               out_failed;
  logic [15:0]                        out_rate;

  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  sfdh_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (s_axis_tuser),
    .rx_byte_i  (s_axis_tdata),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  sfdh_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .cmd_o   (queue_cmd)
  );

  sfdh_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_valid_i  (cmd_valid),
    .cmd_i        (queue_cmd),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_kind_o   (m_axis_tuser),
    .out_words_o  (out_words),
    .out_failed_o (out_failed),
    .out_rate_o   (out_rate)
  );

  assign m_axis_tdata = {(OUT_DATA_W - PAY_W)'(0), out_rate, out_failed, out_words};

endmodule
`default_nettype wire

// ===== rtl/core/sfdh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deframer front end
// Shifts received bytes into the frame window, keeps a running byte sum and
// issues a command for each tick and each frame that passes the check.
// ----------------------------------------------------------------------------
module sfdh_front import sfdh_pkg::*; #(
  parameter int unsigned FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic       req_type_i,
  input  wire logic [7:0] rx_byte_i,
  output logic            push_o,
  output cmd_t            cmd_o
);

  localparam int unsigned FILL_W = $clog2(FRAME_BYTES);
  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(FRAME_BYTES - 1);

  logic [FRAME_BYTES-1:0][7:0] win_q, win_d;
  logic [7:0]                  sum_q, sum_d;
  logic [FILL_W-1:0]           fill_q, fill_d;
  logic                        byte_acc;
  logic                        good;

  assign byte_acc = accept_i && (req_type_i == REQ_BYTE);

  always_comb begin
    for (int k = 0; k < FRAME_BYTES - 1; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[FRAME_BYTES-1] = rx_byte_i;
    sum_d = sum_q - win_q[0] + rx_byte_i;
  end

  // The check sums bytes 1 and up, so the new oldest byte is taken back out.
  assign good = (fill_q == FILL_LAST) && (win_d[0] == SYNC_FIRST) &&
                (win_d[1] == SYNC_SECOND) && ((sum_d - win_d[0]) == 8'd0);

  always_comb begin
    fill_d = fill_q;
    if (byte_acc) begin
      if (good) begin
        fill_d = '0;
      end else if (fill_q != FILL_LAST) begin
        fill_d = fill_q + FILL_W'(1);
      end
    end
  end

  always_comb begin
    cmd_o.is_tick = (req_type_i == REQ_TICK);
    for (int j = 0; j < WORD_COUNT; j++) begin
      cmd_o.words[j] = {win_d[WORD_BASE+4*j],   win_d[WORD_BASE+4*j+1],
                        win_d[WORD_BASE+4*j+2], win_d[WORD_BASE+4*j+3]};
    end
    push_o = accept_i && ((req_type_i == REQ_TICK) || good);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (byte_acc) begin
      win_q  <= win_d;
      sum_q  <= sum_d;
      fill_q <= fill_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sfdh_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command queue
// Short first-in first-out queue of commands between front and back end.
// ----------------------------------------------------------------------------
module sfdh_cmd_fifo import sfdh_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  cmd_t      cmd_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output cmd_t      cmd_o
);

  cmd_t                 mem_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CMD_CNT_W-1:0] count_q;
  logic                 do_push, do_pop;

  assign full_o  = (count_q == CMD_CNT_W'(CMD_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + CMD_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CMD_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CMD_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/sfdh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Health back end
// Holds the link health counters and configuration, executes queued
// commands and drives the registered result stage.
// ----------------------------------------------------------------------------
module sfdh_back import sfdh_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_index_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             out_kind_o,
  output logic [WORD_COUNT-1:0][WORD_W-1:0] out_words_o,
  output logic             out_failed_o,
  output logic [15:0]      out_rate_o
);

  logic [7:0]  stale_limit_q, rate_period_q;
  logic [15:0] good_frames_q, good_frames_d;
  logic [15:0] at_latch_q, at_latch_d;
  logic [7:0]  stale_q, stale_d;
  logic        fail_q, fail_d;
  logic [7:0]  period_q, period_d;
  logic [15:0] rate_q, rate_d;
  logic [7:0]  stale_inc, period_inc;

  assign pop_o = cmd_valid_i && (!out_valid_o || out_ready_i);

  assign stale_inc  = (stale_q != STALE_MAX) ? stale_q + 8'd1 : stale_q;
  assign period_inc = period_q + 8'd1;

  always_comb begin
    good_frames_d = good_frames_q;
    at_latch_d    = at_latch_q;
    stale_d       = stale_q;
    fail_d        = fail_q;
    period_d      = period_q;
    rate_d        = rate_q;
    if (cmd_i.is_tick) begin
      stale_d  = stale_inc;
      fail_d   = fail_q || (stale_inc >= stale_limit_q);
      period_d = period_inc;
      if (period_inc >= rate_period_q) begin
        period_d   = '0;
        rate_d     = good_frames_q - at_latch_q;
        at_latch_d = good_frames_q;
      end
    end else begin
      good_frames_d = good_frames_q + 16'd1;
      stale_d       = '0;
      fail_d        = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_limit_q <= STALE_LIMIT_RESET;
      rate_period_q <= RATE_PERIOD_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_STALE_LIMIT: stale_limit_q <= cfg_data_i;
        CFG_RATE_PERIOD: rate_period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      good_frames_q <= '0;
      at_latch_q    <= '0;
      stale_q       <= '0;
      fail_q        <= 1'b0;
      period_q      <= '0;
      rate_q        <= '0;
      out_valid_o   <= 1'b0;
    end else begin
      if (pop_o) begin
        good_frames_q <= good_frames_d;
        at_latch_q    <= at_latch_d;
        stale_q       <= stale_d;
        fail_q        <= fail_d;
        period_q      <= period_d;
        rate_q        <= rate_d;
        out_valid_o   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_kind_o   <= cmd_i.is_tick ? KIND_HEALTH : KIND_FRAME;
      out_words_o  <= cmd_i.is_tick ? '0 : cmd_i.words;
      out_failed_o <= fail_d;
      out_rate_o   <= rate_d;
    end
  end

endmodule
`default_nettype wire
